### src/keuf_pkg.sv
// shared constants and register codes for the kruskal edge union-find block
`timescale 1ns / 1ps
package keuf_pkg;

   // word field widths
   localparam int NODE_W     = 10;
   localparam int WEIGHT_W   = 32;
   localparam int COST_W     = 48;
   localparam int COUNT_W    = 11;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COST_LIMIT = 1'b1;

   // register reset values
   localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 11'd1024;
   localparam logic [COST_W-1:0]  COST_LIMIT_RST = 48'd0;

   // parameter defaults
   localparam int MAX_NODES_DEF   = 1024;
   localparam int WEIGHT_BITS_DEF = 32;
   localparam int COST_BITS_DEF   = 48;

endpackage

### src/kruskal_edge_union_find.sv
// top level: streaming kruskal edge checker over a union-find forest held in one ram
`timescale 1ns / 1ps
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  -------------------------------------------------
//  req      in   req_valid/req_stall  node_a node_b weight forced blocked start_req last_edge
//  rsp      out  rsp_valid/rsp_stall  accepted running_cost aborted components
//                                     tree_complete verdict_valid
//  csr      in   csr_write            csr_index csr_wdata (0 node_count, 1 cost_limit)
//
//  one word in, one word out. a word walks the parent links from endpoint a to its root,
//  writes compression links back along that path, then does the same from endpoint b, and
//  makes two more writes (the link and the new size) when the edge joins two sets; union
//  by size keeps each walk within log2(MAX_NODES) links. the single forest ram (one read,
//  one write a cycle) sets the pace. a word with start_req first sweeps the whole forest.
//  after reset the same sweep runs with req_stall high. a finished word sits in the output
//  register, so the next word is taken while rsp_stall holds it.
//
module kruskal_edge_union_find #(
   parameter int MAX_NODES   = keuf_pkg::MAX_NODES_DEF,
   parameter int WEIGHT_BITS = keuf_pkg::WEIGHT_BITS_DEF,
   parameter int COST_BITS   = keuf_pkg::COST_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [keuf_pkg::NODE_W-1:0]     req_node_a,
   input  logic [keuf_pkg::NODE_W-1:0]     req_node_b,
   input  logic [keuf_pkg::WEIGHT_W-1:0]   req_weight,
   input  logic                            req_forced,
   input  logic                            req_blocked,
   input  logic                            req_start_req,
   input  logic                            req_last_edge,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_accepted,
   output logic [keuf_pkg::COST_W-1:0]     rsp_running_cost,
   output logic                            rsp_aborted,
   output logic [keuf_pkg::COUNT_W-1:0]    rsp_components,
   output logic                            rsp_tree_complete,
   output logic                            rsp_verdict_valid,

   input  logic                            csr_write,
   input  logic [keuf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [keuf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import keuf_pkg::*;

   // forest ram entry: root flag, then set size for a root or parent index otherwise
   localparam int NODE_BITS  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int SZ_BITS    = NODE_BITS + 1;
   localparam int ENTRY_BITS = SZ_BITS + 1;
   localparam int CNT_BITS   = $clog2(MAX_NODES + 1);
   localparam int CMP_BITS   = (CNT_BITS > COUNT_W) ? CNT_BITS : COUNT_W;
   localparam int SUM_BITS   = ((COST_BITS > WEIGHT_W) ? COST_BITS : WEIGHT_W) + 1;
   localparam int LIM_BITS   = (COST_BITS > COST_W) ? COST_BITS : COST_W;
   localparam int RST_SETS   = (MAX_NODES < int'(NODE_COUNT_RST)) ?
                               MAX_NODES : int'(NODE_COUNT_RST);

   localparam logic [COST_BITS-1:0] COST_MAX  = '1;
   localparam logic [COST_W-1:0]    OUT_MAX   = '1;
   localparam logic [WEIGHT_W-1:0]  W_MASK    = (WEIGHT_BITS >= WEIGHT_W) ? '1 :
                                                WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);
   localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(MAX_NODES - 1);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLEAR  = 4'd1;
   localparam logic [3:0] S_EVAL   = 4'd2;
   localparam logic [3:0] S_WALK   = 4'd3;
   localparam logic [3:0] S_CMP    = 4'd4;
   localparam logic [3:0] S_DECIDE = 4'd5;
   localparam logic [3:0] S_CHECK  = 4'd6;
   localparam logic [3:0] S_LINK1  = 4'd7;
   localparam logic [3:0] S_LINK2  = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   // forest ram
   logic [ENTRY_BITS-1:0] forest_mem [MAX_NODES];
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic [NODE_BITS-1:0]  rd_addr_ff;
   logic [NODE_BITS-1:0]  rd_addr;
   logic                  mem_we;
   logic [NODE_BITS-1:0]  mem_wa;
   logic [ENTRY_BITS-1:0] mem_wd;

   // control
   logic [3:0]            state_ff;
   logic                  go_eval_ff;
   logic                  fsel_ff;
   logic [NODE_BITS-1:0]  clr_idx_ff;

   // latched word
   logic [NODE_W-1:0]     a_ff, b_ff;
   logic [WEIGHT_W-1:0]   w_ff;
   logic                  forced_ff, blocked_ff, last_ff;

   // roots and their sizes
   logic [NODE_BITS-1:0]  ra_ff, rb_ff;
   logic [SZ_BITS-1:0]    sa_ff, sb_ff;

   // graph state and registers
   logic [COST_BITS-1:0]  cost_ff;
   logic                  abort_ff;
   logic                  acc_ff;
   logic [CNT_BITS-1:0]   sets_ff;
   logic [COUNT_W-1:0]    node_count_ff;
   logic [COST_W-1:0]     cost_limit_ff;

   // output register
   logic                  rsp_valid_ff;
   logic                  rsp_accepted_ff;
   logic [COST_W-1:0]     rsp_cost_ff;
   logic                  rsp_aborted_ff;
   logic [COUNT_W-1:0]    rsp_components_ff;
   logic                  rsp_complete_ff;
   logic                  rsp_verdict_ff;

   // decoded and derived values
   logic                  ent_root;
   logic [NODE_BITS-1:0]  ent_par;
   logic [SZ_BITS-1:0]    ent_size;
   logic [NODE_BITS-1:0]  a_idx, b_idx, start_idx, cur_root;
   logic [CMP_BITS-1:0]   nc_ext, n_use;
   logic                  edge_ok;
   logic                  cmp_done;
   logic                  req_take;
   logic                  out_free;
   logic [SUM_BITS-1:0]   cost_sum;
   logic [COST_BITS-1:0]  cost_sat;
   logic                  over_limit;
   logic                  swap_roots;
   logic [NODE_BITS-1:0]  small_root, big_root;
   logic [COST_W-1:0]     cost_out;
   logic                  complete_now;

   assign ent_root = rd_data_ff[ENTRY_BITS-1];
   assign ent_par  = rd_data_ff[NODE_BITS-1:0];
   assign ent_size = rd_data_ff[SZ_BITS-1:0];

   // node range in use: zero counts as one, clipped to the forest depth
   assign nc_ext = CMP_BITS'(node_count_ff);
   assign n_use  = (nc_ext == '0) ? CMP_BITS'(1) :
                   (nc_ext > CMP_BITS'(MAX_NODES)) ? CMP_BITS'(MAX_NODES) : nc_ext;

   assign a_idx     = NODE_BITS'(CMP_BITS'(a_ff));
   assign b_idx     = NODE_BITS'(CMP_BITS'(b_ff));
   assign start_idx = fsel_ff ? b_idx : a_idx;
   assign cur_root  = fsel_ff ? rb_ff : ra_ff;

   // endpoints in range, graph alive, and not a plain blocked edge
   assign edge_ok = !abort_ff && (CMP_BITS'(a_ff) < n_use) && (CMP_BITS'(b_ff) < n_use) &&
                    (forced_ff || !blocked_ff);

   // compression stops at the root or at a node already pointing to it
   assign cmp_done = ent_root || (ent_par == cur_root);

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // saturating cost add and limit compare
   assign cost_sum   = SUM_BITS'(cost_ff) + SUM_BITS'(w_ff & W_MASK);
   assign cost_sat   = (cost_sum > SUM_BITS'(COST_MAX)) ? COST_MAX : COST_BITS'(cost_sum);
   assign over_limit = (cost_limit_ff != '0) &&
                       (LIM_BITS'(cost_ff) > LIM_BITS'(cost_limit_ff));

   // union by size: the smaller set hangs under the larger
   assign swap_roots = (sa_ff > sb_ff);
   assign small_root = swap_roots ? rb_ff : ra_ff;
   assign big_root   = swap_roots ? ra_ff : rb_ff;

   assign cost_out     = (LIM_BITS'(cost_ff) > LIM_BITS'(OUT_MAX)) ? OUT_MAX :
                         COST_W'(cost_ff);
   assign complete_now = last_ff && (sets_ff == CNT_BITS'(1)) && !abort_ff &&
                         ((LIM_BITS'(cost_ff) == LIM_BITS'(cost_limit_ff)) ||
                          (cost_limit_ff == '0));

   // ram read address: next link to follow, or the start of the next walk
   always_comb begin
      rd_addr = rd_addr_ff;
      unique case (state_ff)
         S_EVAL:  rd_addr = a_idx;
         S_WALK:  rd_addr = ent_root ? start_idx : ent_par;
         S_CMP:   rd_addr = cmp_done ? b_idx : ent_par;
         default: rd_addr = rd_addr_ff;
      endcase
   end

   // ram write port
   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_idx_ff;
      mem_wd = {1'b1, SZ_BITS'(1)};
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
         end
         S_CMP: begin
            mem_we = !cmp_done;
            mem_wa = rd_addr_ff;
            mem_wd = {1'b0, SZ_BITS'(cur_root)};
         end
         S_LINK1: begin
            mem_we = 1'b1;
            mem_wa = small_root;
            mem_wd = {1'b0, SZ_BITS'(big_root)};
         end
         S_LINK2: begin
            mem_we = 1'b1;
            mem_wa = big_root;
            mem_wd = {1'b1, SZ_BITS'(sa_ff + sb_ff)};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         forest_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= forest_mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // word latch and root bookkeeping
   always_ff @(posedge clock) begin
      if (req_take) begin
         a_ff       <= req_node_a;
         b_ff       <= req_node_b;
         w_ff       <= req_weight;
         forced_ff  <= req_forced;
         blocked_ff <= req_blocked;
         last_ff    <= req_last_edge;
      end
      if (state_ff == S_WALK && ent_root) begin
         if (fsel_ff) begin
            rb_ff <= rd_addr_ff;
            sb_ff <= ent_size;
         end else begin
            ra_ff <= rd_addr_ff;
            sa_ff <= ent_size;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
         cost_limit_ff <= COST_LIMIT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_COST_LIMIT: cost_limit_ff <= csr_wdata[COST_W-1:0];
            default:        node_count_ff <= node_count_ff;
         endcase
      end
   end

   // sequencer and graph state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         go_eval_ff   <= 1'b0;
         fsel_ff      <= 1'b0;
         clr_idx_ff   <= '0;
         cost_ff      <= '0;
         abort_ff     <= 1'b0;
         acc_ff       <= 1'b0;
         sets_ff      <= CNT_BITS'(RST_SETS);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  acc_ff  <= 1'b0;
                  fsel_ff <= 1'b0;
                  if (req_start_req) begin
                     cost_ff    <= '0;
                     abort_ff   <= 1'b0;
                     sets_ff    <= CNT_BITS'(n_use);
                     clr_idx_ff <= '0;
                     go_eval_ff <= 1'b1;
                     state_ff   <= S_CLEAR;
                  end else begin
                     state_ff <= S_EVAL;
                  end
               end
            end
            S_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + NODE_BITS'(1);
               if (clr_idx_ff == LAST_NODE) begin
                  state_ff <= go_eval_ff ? S_EVAL : S_IDLE;
               end
            end
            S_EVAL: begin
               // read of endpoint a is issued here
               state_ff <= edge_ok ? S_WALK : S_DONE;
            end
            S_WALK: begin
               if (ent_root) begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if (cmp_done) begin
                  if (fsel_ff) begin
                     state_ff <= S_DECIDE;
                  end else begin
                     fsel_ff  <= 1'b1;
                     state_ff <= S_WALK;
                  end
               end
            end
            S_DECIDE: begin
               if (!forced_ff && (ra_ff == rb_ff)) begin
                  state_ff <= S_DONE;
               end else begin
                  cost_ff  <= cost_sat;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (over_limit) begin
                  abort_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  acc_ff   <= 1'b1;
                  state_ff <= (ra_ff != rb_ff) ? S_LINK1 : S_DONE;
               end
            end
            S_LINK1: begin
               state_ff <= S_LINK2;
            end
            S_LINK2: begin
               if (sets_ff > CNT_BITS'(1)) begin
                  sets_ff <= sets_ff - CNT_BITS'(1);
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // result payload, loaded as the word leaves the sequencer
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_accepted_ff   <= acc_ff;
         rsp_cost_ff       <= cost_out;
         rsp_aborted_ff    <= abort_ff;
         rsp_components_ff <= COUNT_W'(CMP_BITS'(sets_ff));
         rsp_complete_ff   <= complete_now;
         rsp_verdict_ff    <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_running_cost  = rsp_cost_ff;
   assign rsp_aborted       = rsp_aborted_ff;
   assign rsp_components    = rsp_components_ff;
   assign rsp_tree_complete = rsp_complete_ff;
   assign rsp_verdict_valid = rsp_verdict_ff;

   // a kept edge never comes from an aborted graph
   a_acc_not_aborted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_aborted)
      else $error("edge kept in an aborted graph");

   // a complete tree is only reported on a last edge with a single set left
   a_complete_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tree_complete |-> rsp_verdict_valid &&
      rsp_components == COUNT_W'(1))
      else $error("complete tree without single component");

   // a start word always goes through the forest sweep
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_start_req |=> state_ff == S_CLEAR)
      else $error("start word skipped the forest sweep");

   // the set count never reaches zero
   a_sets_nonzero: assert property (@(posedge clock) disable iff (reset)
      sets_ff != '0)
      else $error("set count dropped to zero");

endmodule
